// ===== rtl/pwc_pkg.sv =====
// Shared types and constants of the power window controller.
// No dependencies; used by the interfaces, pwc_step and the top level.
package pwc_pkg;

  localparam int unsigned TICK_BITS_DEF = 16;
  localparam int unsigned CFG_W         = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
  localparam logic [CFG_W-1:0] JAM_REV_RST   = 16'd1000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_JAM_REV    = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_TIMING   = 3'd2,
    PH_AUTO     = 3'd3,
    PH_MANUAL   = 3'd4,
    PH_JAM      = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    MOTOR_HALT = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_e;

  typedef struct packed {
    logic drv_up;
    logic drv_dn;
    logic pas_up;
    logic pas_dn;
    logic upper_limit_hit;
    logic lower_limit_hit;
    logic lock_toggle;
    logic jam_hit;
  } in_word_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic [2:0] phase_now;
    logic       lock_active;
    logic       at_upper_limit;
    logic       at_lower_limit;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] jam_reverse_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic       move_up;
    logic [1:0] source_button;
    logic       from_passenger;
    logic       lock_flag;
    logic       up_flag;
    logic       down_flag;
    logic       jam_flag;
  } state_t;

endpackage

// ===== rtl/pwc_if.sv =====
// Valid/ready channels carrying the tick word and the result word.
// Depends on pwc_pkg for the payload types.
interface pwc_in_if;
  import pwc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwc_out_if;
  import pwc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/power_window_controller_unit.sv =====
// Power window controller: one tick word in, one result word out.
// Latency: the result is registered and valid the cycle after the word is taken.
// Throughput: one word per cycle while out_o.ready is high; the output register is refilled in the cycle it is taken.
// Reset: phase idle, all flags and the tick counter cleared, registers at 20/500/1000.
// Depends on pwc_pkg, pwc_if and pwc_step.
module power_window_controller_unit #(
  parameter int unsigned TICK_BITS = pwc_pkg::TICK_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [pwc_pkg::CFG_W-1:0] cfg_data_i,
  pwc_in_if.sink                  in_i,
  pwc_out_if.source               out_o
);
  import pwc_pkg::*;

  cfg_t                 cfg_q;
  state_t               st_q, st_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  out_word_t            out_q, out_d;
  logic                 out_valid_q;
  logic                 in_fire;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;

  pwc_step #(.TICK_BITS(TICK_BITS)) u_step (
    .st_i   (st_q),
    .tick_i (tick_q),
    .word_i (in_i.data),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .tick_o (tick_d),
    .word_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_ticks:    DEBOUNCE_RST,
                 long_press_ticks:  LONG_PRESS_RST,
                 jam_reverse_ticks: JAM_REV_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   cfg_q.debounce_ticks    <= cfg_data_i;
        REG_LONG_PRESS: cfg_q.long_press_ticks  <= cfg_data_i;
        REG_JAM_REV:    cfg_q.jam_reverse_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '{phase: PH_IDLE, default: '0};
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q   <= st_d;
        tick_q <= tick_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_stop_when_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.phase_now != PH_AUTO && out_q.phase_now != PH_MANUAL
     && out_q.phase_now != PH_JAM) |-> out_q.motor_drive == MOTOR_HALT)
    else $error("motor driven outside a move");

  a_jam_drives_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.phase_now == PH_JAM) |-> out_q.motor_drive == MOTOR_DOWN)
    else $error("jam reverse without downward drive");

  a_up_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.motor_drive == MOTOR_UP)
    |-> (!out_q.at_upper_limit && !out_q.at_lower_limit))
    else $error("upward drive with a limit flag set");

  a_phase_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.phase_now == st_q.phase)
    else $error("reported phase differs from state");

endmodule

// ===== rtl/pwc_step.sv =====
// Next-state and result logic for one tick of the window controller.
// Depends on pwc_pkg; purely combinational.
module pwc_step #(
  parameter int unsigned TICK_BITS = pwc_pkg::TICK_BITS_DEF
) (
  input  pwc_pkg::state_t    st_i,
  input  logic [TICK_BITS-1:0] tick_i,
  input  pwc_pkg::in_word_t  word_i,
  input  pwc_pkg::cfg_t      cfg_i,
  output pwc_pkg::state_t    st_o,
  output logic [TICK_BITS-1:0] tick_o,
  output pwc_pkg::out_word_t word_o
);
  import pwc_pkg::*;

  localparam logic [TICK_BITS-1:0] TickMaxT = '1;
  localparam logic [31:0]          TickMax  = 32'(TickMaxT);

  function automatic logic [31:0] cap_thr(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > TickMax) ? TickMax : w;
  endfunction

  logic [3:0]           btn;
  logic                 held;
  logic [TICK_BITS-1:0] tick_inc;
  logic [31:0]          deb_cap, lp_cap, jam_cap;
  logic [CFG_W-1:0]     lp_raw;
  logic [1:0]           idx;
  logic                 own;
  state_t               n;
  logic [TICK_BITS-1:0] t;
  motor_e               motor;

  assign btn = {word_i.pas_dn, word_i.pas_up,
                word_i.drv_dn, word_i.drv_up};
  assign held     = btn[st_i.source_button];
  assign tick_inc = (tick_i == TickMaxT) ? tick_i : tick_i + TICK_BITS'(1);
  assign lp_raw   = (cfg_i.long_press_ticks == '0) ? CFG_W'(1) : cfg_i.long_press_ticks;
  assign deb_cap  = cap_thr(cfg_i.debounce_ticks);
  assign lp_cap   = cap_thr(lp_raw);
  assign jam_cap  = cap_thr(cfg_i.jam_reverse_ticks);

  always_comb begin
    n     = st_i;
    t     = tick_i;
    motor = MOTOR_HALT;
    idx   = '0;
    own   = 1'b0;
    if (word_i.upper_limit_hit) n.up_flag = 1'b1;
    if (word_i.lower_limit_hit) n.down_flag = 1'b1;
    if (word_i.lock_toggle) n.lock_flag = ~st_i.lock_flag;
    if (word_i.jam_hit) n.jam_flag = 1'b1;

    case (st_i.phase)
      PH_IDLE: begin
        // lowest index wins: driver up first
        for (int i = 3; i >= 0; i--) begin
          if (btn[i]) begin
            idx              = 2'(i);
            n.source_button  = idx;
            n.move_up        = ~idx[0];
            n.from_passenger = idx[1];
            t                = '0;
            n.phase          = PH_DEBOUNCE;
          end
        end
      end
      PH_DEBOUNCE: begin
        t = tick_inc;
        if (32'(tick_inc) >= deb_cap) begin
          t       = '0;
          n.phase = held ? PH_TIMING : PH_IDLE;
        end
      end
      PH_TIMING: begin
        if (!held) begin
          n.phase = (st_i.from_passenger && n.lock_flag) ? PH_IDLE : PH_AUTO;
        end else begin
          t = tick_inc;
          if (32'(tick_inc) >= lp_cap) begin
            n.phase = (st_i.from_passenger && n.lock_flag) ? PH_IDLE : PH_MANUAL;
          end
        end
      end
      PH_JAM: begin
        t = tick_inc;
        if (32'(tick_inc) >= jam_cap) begin
          n.jam_flag = 1'b0;
          n.phase    = PH_IDLE;
        end else begin
          motor = MOTOR_DOWN;
        end
      end
      PH_AUTO, PH_MANUAL: begin
      end
      default: n.phase = PH_IDLE;
    endcase

    if (n.phase == PH_AUTO || n.phase == PH_MANUAL) begin
      own = n.move_up ? n.up_flag : n.down_flag;
      if (n.jam_flag) begin
        n.phase = PH_JAM;
        t       = '0;
        motor   = MOTOR_DOWN;
      end else if (own || (n.phase == PH_MANUAL && !held)) begin
        n.phase = PH_IDLE;
      end else begin
        if (n.move_up) n.down_flag = 1'b0;
        else n.up_flag = 1'b0;
        motor = n.move_up ? MOTOR_UP : MOTOR_DOWN;
      end
    end
  end

  assign st_o   = n;
  assign tick_o = t;
  assign word_o = '{motor_drive:    motor,
                    phase_now:      n.phase,
                    lock_active:    n.lock_flag,
                    at_upper_limit: n.up_flag,
                    at_lower_limit: n.down_flag};

endmodule
